// ===== src/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package lr_pkg;

	// Fixed field widths of the line and pixel words
	localparam int PIX_W = 6;
	localparam int COLOR_W = 24;

	// Default coordinate width actually used inside the datapath
	localparam int COORD_BITS_DEF = 6;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAW
	} lr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} lr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;
	} lr_status_t;

endpackage

// ===== src/lr_if.sv =====
// Channel interfaces: line segment words in, pixel words out.
interface lr_line_if
	import lr_pkg::*;
	();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] start_x;
	logic [PIX_W-1:0] start_y;
	logic [PIX_W-1:0] end_x;
	logic [PIX_W-1:0] end_y;
	logic [COLOR_W-1:0] line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface lr_pixel_if
	import lr_pkg::*;
	();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== src/lr_ctrl.sv =====
// Controller state machine: accepts a line, then steps out its pixels.
module lr_ctrl
	import lr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  lr_status_t status,
	output lr_cmd_t    cmd
);

	lr_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/lr_datapath.sv =====
// Datapath: line setup and incremental minor-axis stepping.
module lr_datapath
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
)(
	input  logic               clk,
	input  lr_cmd_t            cmd,
	output lr_status_t         status,
	input  logic [PIX_W-1:0]   start_x,
	input  logic [PIX_W-1:0]   start_y,
	input  logic [PIX_W-1:0]   end_x,
	input  logic [PIX_W-1:0]   end_y,
	input  logic [COLOR_W-1:0] line_color,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last_pixel
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0] ax, ay, bx, by;
	logic signed [DW-1:0] dx, dy, adx, ady;
	logic signed [DW-1:0] maj_a, min_a, maj_b, min_b;
	logic signed [DW-1:0] lo_maj, lo_min, hi_maj, hi_min;
	logic signed [DW-1:0] span_c, delta_c, adelta_c;
	logic                 xmaj_c;

	logic [CB-1:0]        major_q, minor_q, span_q, adelta_q, rem_q, acc_q;
	logic                 neg_q, xmaj_q;
	logic [COLOR_W-1:0]   color_q;
	logic [CB:0]          acc_sum;
	logic [CB-1:0]        px, py;

	// Setup: sign-extend, pick major axis, order endpoints along it
	always_comb begin
		ax = DW'($signed(start_x[CB-1:0]));
		ay = DW'($signed(start_y[CB-1:0]));
		bx = DW'($signed(end_x[CB-1:0]));
		by = DW'($signed(end_y[CB-1:0]));
		dx = bx - ax;
		dy = by - ay;
		adx = dx[DW-1] ? -dx : dx;
		ady = dy[DW-1] ? -dy : dy;
		xmaj_c = $unsigned(adx) > $unsigned(ady);
		maj_a = xmaj_c ? ax : ay;
		min_a = xmaj_c ? ay : ax;
		maj_b = xmaj_c ? bx : by;
		min_b = xmaj_c ? by : bx;
		if (maj_a > maj_b) begin
			lo_maj = maj_b;
			lo_min = min_b;
			hi_maj = maj_a;
			hi_min = min_a;
		end else begin
			lo_maj = maj_a;
			lo_min = min_a;
			hi_maj = maj_b;
			hi_min = min_b;
		end
		span_c = hi_maj - lo_maj;
		delta_c = hi_min - lo_min;
		adelta_c = delta_c[DW-1] ? -delta_c : delta_c;
	end

	// Remainder accumulator: |delta| never exceeds span, so one subtract suffices
	assign acc_sum = {1'b0, acc_q} + {1'b0, adelta_q};

	// Per-line registers and stepping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			major_q <= lo_maj[CB-1:0];
			minor_q <= lo_min[CB-1:0];
			span_q <= span_c[CB-1:0];
			rem_q <= span_c[CB-1:0];
			adelta_q <= adelta_c[CB-1:0];
			neg_q <= delta_c[DW-1];
			xmaj_q <= xmaj_c;
			acc_q <= '0;
			color_q <= line_color;
		end else if (cmd.step) begin
			major_q <= major_q + 1'b1;
			rem_q <= rem_q - 1'b1;
			if (acc_sum >= {1'b0, span_q}) begin
				acc_q <= CB'(acc_sum - {1'b0, span_q});
				minor_q <= neg_q ? minor_q - 1'b1 : minor_q + 1'b1;
			end else begin
				acc_q <= acc_sum[CB-1:0];
			end
		end
	end

	// Pixel word from the current position
	assign px = xmaj_q ? major_q : minor_q;
	assign py = xmaj_q ? minor_q : major_q;
	assign pixel_x = PIX_W'($signed(px));
	assign pixel_y = PIX_W'($signed(py));
	assign pixel_color = color_q;
	assign last_pixel = (rem_q == '0);
	assign status.last = last_pixel;

endmodule

// ===== src/line_rasterizer_unit.sv =====
// Top level of the line rasterizer: controller plus datapath.
//
//  channel     dir  word                                        handshake
//  line_in     in   start_x, start_y, end_x, end_y, line_color   valid/ready
//  pixel_out   out  pixel_x, pixel_y, pixel_color, last_pixel     valid/ready
//
// With no stalls, a line is accepted and set up in ST_IDLE, then one pixel
// per cycle leaves along the major axis (span + 1 pixels, at most
// 2^COORD_BITS). The pace is set by the single stepping accumulator.
// A new line is accepted only after the last pixel of the previous one leaves.
// Reset clears only the controller state; no other state survives a line.
// A stall on pixel_out holds the current pixel word unchanged.
module line_rasterizer_unit
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
)(
	input  logic       clk,
	input  logic       arst_n,
	lr_line_if.sink    line_in,
	lr_pixel_if.source pixel_out
);

	lr_cmd_t    cmd;
	lr_status_t status;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (line_in.valid),
		.in_ready  (line_in.ready),
		.out_valid (pixel_out.valid),
		.out_ready (pixel_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.start_x     (line_in.start_x),
		.start_y     (line_in.start_y),
		.end_x       (line_in.end_x),
		.end_y       (line_in.end_y),
		.line_color  (line_in.line_color),
		.pixel_x     (pixel_out.pixel_x),
		.pixel_y     (pixel_out.pixel_y),
		.pixel_color (pixel_out.pixel_color),
		.last_pixel  (pixel_out.last_pixel)
	);

	// One line in flight: never ready for a line while a pixel is offered
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		!(line_in.ready && pixel_out.valid))
		else $error("line accepted while pixels pending");

	// An accepted line shows its first pixel on the next cycle
	a_first_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		line_in.valid && line_in.ready |=> pixel_out.valid)
		else $error("no pixel after line accepted");

	// After the last pixel the block is ready for a new line
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.ready && pixel_out.last_pixel |=> line_in.ready)
		else $error("not ready after last pixel");

	// Within a line the pixels keep coming and the color holds
	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.ready && !pixel_out.last_pixel |=>
			pixel_out.valid && $stable(pixel_out.pixel_color))
		else $error("line ended early or color changed");

endmodule
